// ----- hw/rtl/ed2c_pkg.sv -----
package ed2c_pkg;

    localparam int DAYS_W   = 15;
    localparam int MILLIS_W = 27;

    // reciprocal constants, m = ceil(2^k / d), exact over the operand range
    localparam logic [27:0] MUL_1000 = 28'd137438954;  // k = 37, 27-bit operand
    localparam logic [18:0] MUL_60   = 19'd279621;     // k = 24, 18-bit operand
    localparam logic [18:0] MUL_3600 = 19'd298262;     // k = 30, 18-bit operand
    localparam logic [15:0] MUL_1461 = 16'd45934;      // k = 26, 16-bit operand
    localparam logic [16:0] MUL_7    = 17'd74899;      // k = 19, 16-bit operand

    localparam logic [14:0] TABLE_END_DAY = 15'd27394;  // 1 january 2033
    localparam logic [9:0]  EPOCH_OFS     = 10'd731;    // days from 1956-01-01 to 1958-01-01
    localparam logic [1:0]  WDAY_OFS      = 2'd3;       // 1958-01-01 was a wednesday
    localparam logic [10:0] QUAD_DAYS     = 11'd1461;
    localparam logic [7:0]  YEAR_BASE     = 8'd56;
    localparam logic [5:0]  MAX_HOUR      = 6'd31;

    // first day of month idx, zero-based day of year
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            4'd12:   base = 9'd365;
            default: base = 9'd0;
        endcase
        return base + 9'((leap && (idx >= 4'd2)) ? 1 : 0);
    endfunction

endpackage

// ----- hw/rtl/ed2c_time.sv -----
module ed2c_time (
    input  logic                           i_clk,
    input  logic [ed2c_pkg::MILLIS_W-1:0]  i_day_millis,
    output logic [5:0]                     o_second_of_minute,
    output logic [5:0]                     o_minute_of_hour,
    output logic [4:0]                     o_hour_of_day
);
    import ed2c_pkg::*;

    // stage 1: whole seconds
    logic [54:0] ms_prod;
    logic [17:0] r_secs;

    // stage 2: minutes and hours of the day
    logic [36:0] min_prod;
    logic [36:0] hour_prod;
    logic [17:0] r_secs_d;
    logic [11:0] r_mins;
    logic [5:0]  r_hours;

    // stage 3: remainders
    logic [17:0] sec_full;
    logic [11:0] min_full;

    assign ms_prod = 55'(i_day_millis) * 55'(MUL_1000);

    always_ff @(posedge i_clk) begin
        r_secs <= ms_prod[54:37];
    end

    assign min_prod  = 37'(r_secs) * 37'(MUL_60);
    assign hour_prod = 37'(r_secs) * 37'(MUL_3600);

    always_ff @(posedge i_clk) begin
        r_secs_d <= r_secs;
        r_mins   <= min_prod[35:24];
        r_hours  <= hour_prod[35:30];
    end

    assign sec_full = r_secs_d - 18'(r_mins) * 18'd60;
    assign min_full = r_mins - 12'(r_hours) * 12'd60;

    always_ff @(posedge i_clk) begin
        o_second_of_minute <= sec_full[5:0];
        o_minute_of_hour   <= min_full[5:0];
        o_hour_of_day      <= (r_hours > MAX_HOUR) ? MAX_HOUR[4:0] : r_hours[4:0];
    end

endmodule

// ----- hw/rtl/ed2c_date.sv -----
module ed2c_date (
    input  logic                         i_clk,
    input  logic [ed2c_pkg::DAYS_W-1:0]  i_epoch_days,
    input  logic                         i_one_based,
    output logic [2:0]                   o_weekday,
    output logic [7:0]                   o_years_since_1900,
    output logic [8:0]                   o_day_of_year,
    output logic [3:0]                   o_month_index,
    output logic [4:0]                   o_day_of_month,
    output logic                         o_out_of_range
);
    import ed2c_pkg::*;

    // stage 1: four-year cycle and week quotients
    logic [15:0] shifted;
    logic [31:0] quad_prod;
    logic [15:0] wk_sum;
    logic [31:0] wk_prod;
    logic [15:0] r_shifted;
    logic [4:0]  r_quad;
    logic [15:0] r_wk_sum;
    logic [12:0] r_wk_q;
    logic        r_oor1;

    // stage 2: year within the cycle
    logic [15:0] quad_rem;
    logic [10:0] cyc_day;
    logic [15:0] wk_rem;
    logic [1:0]  yq;
    logic [10:0] ystart;
    logic [10:0] yday_full;
    logic [7:0]  r_year;
    logic [8:0]  r_yday;
    logic        r_leap;
    logic [2:0]  r_wday;
    logic        r_oor2;

    // stage 3: month search
    logic [10:0] month_ge;
    logic [3:0]  mon;
    logic [8:0]  mday_full;

    assign shifted   = 16'(i_epoch_days) + 16'(EPOCH_OFS);
    assign quad_prod = 32'(shifted) * 32'(MUL_1461);
    assign wk_sum    = 16'(i_epoch_days) + 16'(WDAY_OFS);
    assign wk_prod   = 32'(wk_sum) * 32'(MUL_7);

    always_ff @(posedge i_clk) begin
        r_shifted <= shifted;
        r_quad    <= quad_prod[30:26];
        r_wk_sum  <= wk_sum;
        r_wk_q    <= wk_prod[31:19];
        r_oor1    <= (i_epoch_days >= TABLE_END_DAY);
    end

    assign quad_rem = r_shifted - 16'(r_quad) * 16'(QUAD_DAYS);
    assign cyc_day  = quad_rem[10:0];
    assign wk_rem   = r_wk_sum - 16'(r_wk_q) * 16'd7;

    // the first year of each cycle is the leap year
    always_comb begin
        if (cyc_day < 11'd366) begin
            yq     = 2'd0;
            ystart = 11'd0;
        end else if (cyc_day < 11'd731) begin
            yq     = 2'd1;
            ystart = 11'd366;
        end else if (cyc_day < 11'd1096) begin
            yq     = 2'd2;
            ystart = 11'd731;
        end else begin
            yq     = 2'd3;
            ystart = 11'd1096;
        end
    end

    assign yday_full = cyc_day - ystart;

    always_ff @(posedge i_clk) begin
        r_year <= YEAR_BASE + 8'({r_quad, 2'b00}) + 8'(yq);
        r_yday <= yday_full[8:0];
        r_leap <= (yq == 2'd0);
        r_wday <= wk_rem[2:0];
        r_oor2 <= r_oor1;
    end

    always_comb begin
        for (int m = 0; m < 11; m++) begin
            month_ge[m] = (r_yday >= month_start(r_leap, 4'(m + 1)));
        end
        mon = 4'd0;
        for (int m = 0; m < 11; m++) begin
            mon = mon + 4'(month_ge[m]);
        end
    end

    assign mday_full = r_yday - month_start(r_leap, mon) + 9'd1;

    always_ff @(posedge i_clk) begin
        o_weekday          <= r_wday + 3'(i_one_based);
        o_years_since_1900 <= r_oor2 ? 8'd0 : r_year;
        o_day_of_year      <= r_oor2 ? 9'd0 : r_yday + 9'(i_one_based);
        o_month_index      <= r_oor2 ? 4'd0 : mon;
        o_day_of_month     <= r_oor2 ? 5'd0 : mday_full[4:0];
        o_out_of_range     <= r_oor2;
    end

endmodule

// ----- hw/rtl/epoch_days_to_calendar_core.sv -----
// an accepted start beat reaches the o_valid result beat through the reciprocal, year split and month search stages
// throughput: one beat per cycle; busy is held low, the pipeline never stalls
// the result is on the ports for one cycle only, the receiver cannot stall
// reset (i_rst_n low, synchronous) clears the valid pipeline and r_one_based
module epoch_days_to_calendar_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ed2c_pkg::DAYS_W-1:0]  i_epoch_days,
    input  logic [ed2c_pkg::MILLIS_W-1:0] i_day_millis,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    output logic                         o_valid,
    output logic [5:0]                   o_second_of_minute,
    output logic [5:0]                   o_minute_of_hour,
    output logic [4:0]                   o_hour_of_day,
    output logic [2:0]                   o_weekday,
    output logic [7:0]                   o_years_since_1900,
    output logic [8:0]                   o_day_of_year,
    output logic [3:0]                   o_month_index,
    output logic [4:0]                   o_day_of_month,
    output logic                         o_out_of_range
);
    import ed2c_pkg::*;

    // valid bits, one per stage: reciprocal products, year split, month search
    logic [2:0] r_vld;
    logic [2:0] n_vld;
    logic       r_one_based;

    // every beat runs the same fixed path, so there is nothing to hold off
    assign busy  = 1'b0;
    assign n_vld = {r_vld[1:0], start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= 3'b000;
            r_one_based <= 1'b0;
        end else begin
            r_vld <= n_vld;
            // the user must change config only while idle (unchecked here); it is applied at the last stage
            if (i_cfg_we) begin
                r_one_based <= i_cfg_wdata;
            end
        end
    end

    assign o_valid = r_vld[2];

    // time of day: millis -> seconds -> minutes/hours -> remainders
    ed2c_time u_time (
        .i_clk              (i_clk),
        .i_day_millis       (i_day_millis),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day)
    );

    // calendar: four-year cycle split, year in cycle, month table search
    ed2c_date u_date (
        .i_clk              (i_clk),
        .i_epoch_days       (i_epoch_days),
        .i_one_based        (r_one_based),
        .o_weekday          (o_weekday),
        .o_years_since_1900 (o_years_since_1900),
        .o_day_of_year      (o_day_of_year),
        .o_month_index      (o_month_index),
        .o_day_of_month     (o_day_of_month),
        .o_out_of_range     (o_out_of_range)
    );

    // a start beat shows up as a result beat on o_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##3 o_valid)
        else $error("start beat did not produce a result beat");

    // out of table days clear year, day of year, month and day of month; the weekday is kept
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |->
            (o_years_since_1900 == 8'd0 && o_month_index == 4'd0 &&
             o_day_of_month == 5'd0 && o_day_of_year == 9'd0))
        else $error("calendar fields not cleared when out of range");

    // in range dates are well formed
    a_date_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_of_range) |->
            (o_month_index <= 4'd11 && o_day_of_month != 5'd0 &&
             o_years_since_1900 >= 8'd58))
        else $error("malformed calendar date");

    // time-of-day remainders stay in range
    a_time_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_second_of_minute <= 6'd59 && o_minute_of_hour <= 6'd59))
        else $error("second or minute out of range");

endmodule
